// ----- rtl/ofg_pkg.sv -----
//------------------------------------------------------------------------------
// ofg_pkg
// Shared types, codes, widths and saturation helpers for the flow-field grid.
//------------------------------------------------------------------------------
`default_nettype none

package ofg_pkg;

	localparam int GRID_SIZE_DEF = 32;
	localparam int QUEUE_DEPTH   = 2;

	localparam int CELL_W = 12;
	localparam int POS_W  = 20;
	localparam int VEC_W  = 24;
	localparam int OP_W   = 2;

	// front divider: cell index and neighborhood reach
	localparam int FDIV_NW = 16;
	localparam int FDIV_QW = 14;

	// back datapath
	localparam int DIFF_W = 30;
	localparam int MAG_W  = 28;
	localparam int SQ_W   = 56;
	localparam int D2_W   = 57;
	localparam int PROD_W = 40;
	localparam int NUM_W  = 60;
	localparam int QUO_W  = 25;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
	localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

	localparam logic REG_CELL_WIDTH  = 1'b0;
	localparam logic REG_CELL_HEIGHT = 1'b1;

	localparam logic [CELL_W-1:0] CELL_RESET = 12'd32;

	localparam logic [1:0] STEP_X = 2'd0;
	localparam logic [1:0] STEP_Y = 2'd1;
	localparam logic [1:0] STEP_R = 2'd2;

	typedef struct packed {
		logic [CELL_W-1:0] cw;
		logic [CELL_W-1:0] ch;
		logic [CELL_W-1:0] cmin;
	} ofg_cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [CELL_W-1:0] ox;
		logic [CELL_W-1:0] oy;
		logic [12:0]       reach;
	} ofg_item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_START,
		F_WAIT,
		F_PUSH
	} ofg_fstate_t;

	typedef enum logic [4:0] {
		B_INIT,
		B_IDLE,
		B_CLEAR,
		B_WIN,
		B_CTR,
		B_SQX,
		B_SQY,
		B_SUM,
		B_MULX,
		B_MULY,
		B_DIVS,
		B_DIV,
		B_WR,
		B_NEXT,
		B_QRD,
		B_QWAIT,
		B_DONE
	} ofg_bstate_t;

	function automatic logic signed [VEC_W-1:0] contrib(input logic [QUO_W-1:0] quo,
			input logic ovf, input logic neg);
		logic [QUO_W-1:0] q;
		q = (ovf || quo > 25'h1000000) ? 25'h1000000 : quo;
		if (!neg) begin
			return (q > 25'h7FFFFF) ? 24'sh7FFFFF : signed'(q[VEC_W-1:0]);
		end
		return (q > 25'h800000) ? 24'sh800000 : signed'(-q[VEC_W-1:0]);
	endfunction

	function automatic logic signed [VEC_W-1:0] sat_add(input logic signed [VEC_W-1:0] v,
			input logic signed [VEC_W-1:0] c);
		logic signed [VEC_W:0] s;
		s = 25'(v) + 25'(c);
		if (s[VEC_W] != s[VEC_W-1]) begin
			return s[VEC_W] ? 24'sh800000 : 24'sh7FFFFF;
		end
		return s[VEC_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ofg_if.sv -----
//------------------------------------------------------------------------------
// ofg_if
// Valid/ready channels for request words and result words.
//------------------------------------------------------------------------------
`default_nettype none

interface ofg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [19:0] pos_x;
	logic [19:0] pos_y;
	logic [19:0] obstacle_radius;

	modport source (output valid, operation, pos_x, pos_y, obstacle_radius, input ready);
	modport sink   (input valid, operation, pos_x, pos_y, obstacle_radius, output ready);
endinterface

interface ofg_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] force_x;
	logic signed [23:0] force_y;
	logic               in_grid;

	modport source (output valid, force_x, force_y, in_grid, input ready);
	modport sink   (input valid, force_x, force_y, in_grid, output ready);
endinterface

`default_nettype wire

// ----- rtl/ofg_div.sv -----
//------------------------------------------------------------------------------
// ofg_div
// Restoring unsigned divider, one quotient bit per cycle, with overflow flag.
//------------------------------------------------------------------------------
`default_nettype none

module ofg_div #(
	parameter int NW = ofg_pkg::FDIV_NW,
	parameter int DW = ofg_pkg::CELL_W,
	parameter int QW = ofg_pkg::FDIV_QW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo,
	output logic          ovf
);

	localparam int HW   = NW - QW;
	localparam int XW   = (HW > DW) ? HW : DW;
	localparam int CNTW = $clog2(QW + 1);

	logic [DW-1:0]   r_q;
	logic [DW-1:0]   d_q;
	logic [QW-1:0]   n_q;
	logic [QW-1:0]   quo_q;
	logic            ovf_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW:0]     rs;
	logic [DW:0]     diff;
	logic            ge;

	always_comb begin
		rs   = {r_q, n_q[QW-1]};
		ge   = rs >= {1'b0, d_q};
		diff = rs - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(QW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNTW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= DW'(num[NW-1:QW]);
			n_q   <= num[QW-1:0];
			d_q   <= den;
			ovf_q <= XW'(num[NW-1:QW]) >= XW'(den);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			r_q   <= ge ? diff[DW-1:0] : rs[DW-1:0];
			n_q   <= n_q << 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign ovf  = ovf_q;

endmodule

`default_nettype wire

// ----- rtl/ofg_front.sv -----
//------------------------------------------------------------------------------
// ofg_front
// Accept request words, find the obstacle or query cell and the reach.
//------------------------------------------------------------------------------
`default_nettype none

module ofg_front (
	input  logic               clk,
	input  logic               arst_n,
	ofg_in_if.sink             req,
	input  ofg_pkg::ofg_cfg_t  cfg,
	input  logic               hold,
	output logic               push,
	output ofg_pkg::ofg_item_t push_item,
	input  logic               full
);

	ofg_pkg::ofg_fstate_t state_q, state_d;

	logic [1:0]                  step_q;
	logic [ofg_pkg::OP_W-1:0]    op_q;
	logic [ofg_pkg::POS_W-1:0]   px_q;
	logic [ofg_pkg::POS_W-1:0]   py_q;
	logic [ofg_pkg::POS_W-1:0]   rad_q;
	logic [ofg_pkg::CELL_W-1:0]  ox_q;
	logic [ofg_pkg::CELL_W-1:0]  oy_q;
	logic [12:0]                 reach_q;
	logic                        accept;
	logic                        div_start;
	logic [ofg_pkg::FDIV_NW-1:0] div_num;
	logic [ofg_pkg::CELL_W-1:0]  div_den;
	logic                        div_done;
	logic [ofg_pkg::FDIV_QW-1:0] div_quo;
	logic [12:0]                 rad_ceil;

	assign req.ready = (state_q == ofg_pkg::F_IDLE) && !hold;
	assign accept    = req.valid && req.ready;

	always_comb begin
		rad_ceil = 13'((21'(rad_q) + 21'd255) >> 8);
		case (step_q)
			ofg_pkg::STEP_X: begin
				div_num = 16'(px_q[19:8]);
				div_den = cfg.cw;
			end
			ofg_pkg::STEP_Y: begin
				div_num = 16'(py_q[19:8]);
				div_den = cfg.ch;
			end
			default: begin
				div_num = 16'(14'(rad_ceil) + 14'(cfg.cmin) - 14'd1);
				div_den = cfg.cmin;
			end
		endcase
	end

	ofg_div #(
		.NW(ofg_pkg::FDIV_NW),
		.DW(ofg_pkg::CELL_W),
		.QW(ofg_pkg::FDIV_QW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.ovf   ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ofg_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		push      = 1'b0;
		case (state_q)
			ofg_pkg::F_IDLE: begin
				if (accept) state_d = ofg_pkg::F_START;
			end
			ofg_pkg::F_START: begin
				div_start = 1'b1;
				state_d   = ofg_pkg::F_WAIT;
			end
			ofg_pkg::F_WAIT: begin
				if (div_done) state_d = (step_q == ofg_pkg::STEP_R) ? ofg_pkg::F_PUSH
					: ofg_pkg::F_START;
			end
			ofg_pkg::F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = ofg_pkg::F_IDLE;
				end
			end
			default: state_d = ofg_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.operation;
			px_q   <= req.pos_x;
			py_q   <= req.pos_y;
			rad_q  <= req.obstacle_radius;
			step_q <= ofg_pkg::STEP_X;
		end else if (state_q == ofg_pkg::F_WAIT && div_done) begin
			case (step_q)
				ofg_pkg::STEP_X: ox_q <= div_quo[ofg_pkg::CELL_W-1:0];
				ofg_pkg::STEP_Y: oy_q <= div_quo[ofg_pkg::CELL_W-1:0];
				default:         reach_q <= div_quo[12:0];
			endcase
			step_q <= step_q + 2'd1;
		end
	end

	always_comb begin
		push_item.op    = op_q;
		push_item.pos_x = px_q;
		push_item.pos_y = py_q;
		push_item.ox    = ox_q;
		push_item.oy    = oy_q;
		push_item.reach = reach_q;
	end

endmodule

`default_nettype wire

// ----- rtl/ofg_queue.sv -----
//------------------------------------------------------------------------------
// ofg_queue
// Short FIFO of classified items between the front and back parts.
//------------------------------------------------------------------------------
`default_nettype none

module ofg_queue #(
	parameter int DEPTH = ofg_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ofg_pkg::ofg_item_t din,
	output logic               full,
	input  logic               pop,
	output ofg_pkg::ofg_item_t dout,
	output logic               not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ofg_pkg::ofg_item_t mem_q [DEPTH];
	logic [PW-1:0]      wr_q;
	logic [PW-1:0]      rd_q;
	logic [CW-1:0]      cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule

`default_nettype wire

// ----- rtl/ofg_back.sv -----
//------------------------------------------------------------------------------
// ofg_back
// Carry out clear, add-obstacle and query items on the force store.
//------------------------------------------------------------------------------
`default_nettype none

module ofg_back #(
	parameter int GRID_SIZE = ofg_pkg::GRID_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ofg_pkg::ofg_cfg_t  cfg,
	input  logic               head_valid,
	input  ofg_pkg::ofg_item_t head,
	output logic               pop,
	output logic               init_busy,
	ofg_out_if.source          rsp
);

	localparam int CW    = $clog2(GRID_SIZE);
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int VW    = ofg_pkg::VEC_W;

	ofg_pkg::ofg_bstate_t state_q, state_d;

	logic [2*VW-1:0] mem [DEPTH];
	logic [2*VW-1:0] rd_q;

	ofg_pkg::ofg_item_t item_q;
	logic               ingrid_q;
	logic [CW-1:0]      x_q, y_q, y0_q, x1_q, y1_q;
	logic [AW-1:0]      sweep_q;

	logic [ofg_pkg::MAG_W-1:0]  mx_q, my_q;
	logic                       negx_q, negy_q;
	logic [ofg_pkg::SQ_W-1:0]   sqx_q, sqy_q;
	logic [ofg_pkg::D2_W-1:0]   d2_q;
	logic [ofg_pkg::PROD_W-1:0] prx_q, pry_q;

	logic signed [VW-1:0] res_fx_q, res_fy_q;
	logic                 res_in_q;
	logic                 out_valid_q;
	logic signed [VW-1:0] out_fx_q, out_fy_q;
	logic                 out_in_q;

	logic [AW-1:0]              cell_addr;
	logic signed [14:0]         rch, ox_s, oy_s, gmax;
	logic signed [14:0]         xlo_r, xhi_r, ylo_r, yhi_r, xlo, xhi, ylo, yhi;
	logic                       win_empty;
	logic [20:0]                cxp, cyp;
	logic signed [ofg_pkg::DIFF_W-1:0] dx, dy;
	logic [ofg_pkg::D2_W-1:0]   d2;
	logic                       div_start;
	logic                       dvx_done, dvy_done;
	logic [ofg_pkg::QUO_W-1:0]  qx, qy;
	logic                       ovx, ovy;
	logic signed [VW-1:0]       new_fx, new_fy;
	logic                       we;
	logic [AW-1:0]              waddr;
	logic [2*VW-1:0]            wdata;
	logic                       load_out;

	assign init_busy = (state_q == ofg_pkg::B_INIT);
	assign cell_addr = AW'(x_q) * AW'(GRID_SIZE) + AW'(y_q);

	always_comb begin
		rch   = signed'(15'(item_q.reach)) + 15'sd2;
		ox_s  = signed'(15'(item_q.ox));
		oy_s  = signed'(15'(item_q.oy));
		gmax  = signed'(15'(GRID_SIZE - 1));
		xlo_r = ox_s - rch;
		xhi_r = ox_s + rch;
		ylo_r = oy_s - rch;
		yhi_r = oy_s + rch;
		xlo   = (xlo_r < 0) ? 15'sd0 : xlo_r;
		ylo   = (ylo_r < 0) ? 15'sd0 : ylo_r;
		xhi   = (xhi_r > gmax) ? gmax : xhi_r;
		yhi   = (yhi_r > gmax) ? gmax : yhi_r;
		win_empty = (xlo > gmax) || (ylo > gmax);

		cxp = 21'({x_q, 1'b1}) * 21'(cfg.cw);
		cyp = 21'({y_q, 1'b1}) * 21'(cfg.ch);
		dx  = signed'({2'b00, cxp, 7'b0}) - signed'(30'(item_q.pos_x));
		dy  = signed'({2'b00, cyp, 7'b0}) - signed'(30'(item_q.pos_y));
		d2  = 57'(sqx_q) + 57'(sqy_q);

		new_fx = ofg_pkg::sat_add(signed'(rd_q[2*VW-1:VW]), ofg_pkg::contrib(qx, ovx, negx_q));
		new_fy = ofg_pkg::sat_add(signed'(rd_q[VW-1:0]), ofg_pkg::contrib(qy, ovy, negy_q));
	end

	ofg_div #(
		.NW(ofg_pkg::NUM_W),
		.DW(ofg_pkg::D2_W),
		.QW(ofg_pkg::QUO_W)
	) u_divx (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({prx_q, 20'b0}),
		.den   (d2_q),
		.done  (dvx_done),
		.quo   (qx),
		.ovf   (ovx)
	);

	ofg_div #(
		.NW(ofg_pkg::NUM_W),
		.DW(ofg_pkg::D2_W),
		.QW(ofg_pkg::QUO_W)
	) u_divy (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({pry_q, 20'b0}),
		.den   (d2_q),
		.done  (dvy_done),
		.quo   (qy),
		.ovf   (ovy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ofg_pkg::B_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		we        = 1'b0;
		waddr     = cell_addr;
		wdata     = {new_fx, new_fy};
		load_out  = 1'b0;
		case (state_q)
			ofg_pkg::B_INIT: begin
				we    = 1'b1;
				waddr = sweep_q;
				wdata = '0;
				if (sweep_q == AW'(DEPTH - 1)) state_d = ofg_pkg::B_IDLE;
			end
			ofg_pkg::B_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					case (head.op)
						ofg_pkg::OP_CLEAR: state_d = ofg_pkg::B_CLEAR;
						ofg_pkg::OP_ADD:   state_d = ofg_pkg::B_WIN;
						ofg_pkg::OP_QUERY: state_d = ofg_pkg::B_QRD;
						default:           state_d = ofg_pkg::B_DONE;
					endcase
				end
			end
			ofg_pkg::B_CLEAR: begin
				we    = 1'b1;
				waddr = sweep_q;
				wdata = '0;
				if (sweep_q == AW'(DEPTH - 1)) state_d = ofg_pkg::B_DONE;
			end
			ofg_pkg::B_WIN:  state_d = win_empty ? ofg_pkg::B_DONE : ofg_pkg::B_CTR;
			ofg_pkg::B_CTR:  state_d = ofg_pkg::B_SQX;
			ofg_pkg::B_SQX:  state_d = ofg_pkg::B_SQY;
			ofg_pkg::B_SQY:  state_d = ofg_pkg::B_SUM;
			ofg_pkg::B_SUM:  state_d = (d2 == '0) ? ofg_pkg::B_NEXT : ofg_pkg::B_MULX;
			ofg_pkg::B_MULX: state_d = ofg_pkg::B_MULY;
			ofg_pkg::B_MULY: state_d = ofg_pkg::B_DIVS;
			ofg_pkg::B_DIVS: begin
				div_start = 1'b1;
				state_d   = ofg_pkg::B_DIV;
			end
			ofg_pkg::B_DIV: begin
				if (dvx_done && dvy_done) state_d = ofg_pkg::B_WR;
			end
			ofg_pkg::B_WR: begin
				we      = 1'b1;
				state_d = ofg_pkg::B_NEXT;
			end
			ofg_pkg::B_NEXT: begin
				state_d = (y_q == y1_q && x_q == x1_q) ? ofg_pkg::B_DONE : ofg_pkg::B_CTR;
			end
			ofg_pkg::B_QRD:   state_d = ofg_pkg::B_QWAIT;
			ofg_pkg::B_QWAIT: state_d = ofg_pkg::B_DONE;
			ofg_pkg::B_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ofg_pkg::B_IDLE;
				end
			end
			default: state_d = ofg_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ofg_pkg::B_INIT || state_q == ofg_pkg::B_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
			end else if (state_q == ofg_pkg::B_IDLE) begin
				sweep_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_fx_q <= res_fx_q;
			out_fy_q <= res_fy_q;
			out_in_q <= res_in_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ofg_pkg::B_IDLE: begin
				item_q   <= head;
				ingrid_q <= (32'(head.ox) < GRID_SIZE) && (32'(head.oy) < GRID_SIZE);
				x_q      <= head.ox[CW-1:0];
				y_q      <= head.oy[CW-1:0];
				res_fx_q <= '0;
				res_fy_q <= '0;
				res_in_q <= 1'b0;
			end
			ofg_pkg::B_WIN: begin
				x_q  <= xlo[CW-1:0];
				y_q  <= ylo[CW-1:0];
				y0_q <= ylo[CW-1:0];
				x1_q <= xhi[CW-1:0];
				y1_q <= yhi[CW-1:0];
			end
			ofg_pkg::B_CTR: begin
				negx_q <= dx[ofg_pkg::DIFF_W-1];
				negy_q <= dy[ofg_pkg::DIFF_W-1];
				mx_q   <= dx[ofg_pkg::DIFF_W-1] ? ofg_pkg::MAG_W'(-dx) : ofg_pkg::MAG_W'(dx);
				my_q   <= dy[ofg_pkg::DIFF_W-1] ? ofg_pkg::MAG_W'(-dy) : ofg_pkg::MAG_W'(dy);
			end
			ofg_pkg::B_SQX:  sqx_q <= ofg_pkg::SQ_W'(mx_q) * ofg_pkg::SQ_W'(mx_q);
			ofg_pkg::B_SQY:  sqy_q <= ofg_pkg::SQ_W'(my_q) * ofg_pkg::SQ_W'(my_q);
			ofg_pkg::B_SUM:  d2_q  <= d2;
			ofg_pkg::B_MULX: prx_q <= ofg_pkg::PROD_W'(mx_q) * ofg_pkg::PROD_W'(cfg.cmin);
			ofg_pkg::B_MULY: pry_q <= ofg_pkg::PROD_W'(my_q) * ofg_pkg::PROD_W'(cfg.cmin);
			ofg_pkg::B_NEXT: begin
				if (y_q == y1_q) begin
					y_q <= y0_q;
					x_q <= x_q + 1'b1;
				end else begin
					y_q <= y_q + 1'b1;
				end
			end
			ofg_pkg::B_QWAIT: begin
				if (ingrid_q) begin
					res_fx_q <= signed'(rd_q[2*VW-1:VW]);
					res_fy_q <= signed'(rd_q[VW-1:0]);
					res_in_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[cell_addr];
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.force_x = out_fx_q;
	assign rsp.force_y = out_fy_q;
	assign rsp.in_grid = out_in_q;

endmodule

`default_nettype wire

// ----- rtl/obstacle_flow_field_grid_top.sv -----
//------------------------------------------------------------------------------
// obstacle_flow_field_grid_top
// Repulsive flow-field grid: clear, add obstacle and query force vectors.
//------------------------------------------------------------------------------
// channel | dir | words
// req     | in  | operation, pos_x, pos_y, obstacle_radius
// rsp     | out | force_x, force_y, in_grid (one word per request word)
// apb     | in  | cell_width @0x0, cell_height @0x4
//
// Front: per word, three divisions in turn: cell x, cell y and the reach.
// Query: front plus a read of the stored vector in the back. Clear: sweeps
// every grid cell. Add: works through each cell of the clipped window, using
// the force dividers. After reset a clearing pass over the grid holds req off.
// A two-word queue lets the front accept while the back works or rsp stalls.
//------------------------------------------------------------------------------
`default_nettype none

module obstacle_flow_field_grid_top #(
	parameter int GRID_SIZE = ofg_pkg::GRID_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ofg_in_if.sink      req,
	ofg_out_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [ofg_pkg::CELL_W-1:0] cw_q, ch_q, cw_e, ch_e;
	ofg_pkg::ofg_cfg_t  cfg;
	logic               wr_en;
	logic               push, full, pop, not_empty, init_busy;
	ofg_pkg::ofg_item_t push_item, head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= ofg_pkg::CELL_RESET;
			ch_q <= ofg_pkg::CELL_RESET;
		end else if (wr_en) begin
			if (paddr[2] == ofg_pkg::REG_CELL_WIDTH)  cw_q <= pwdata[ofg_pkg::CELL_W-1:0];
			if (paddr[2] == ofg_pkg::REG_CELL_HEIGHT) ch_q <= pwdata[ofg_pkg::CELL_W-1:0];
		end
	end

	always_comb begin
		prdata   = (paddr[2] == ofg_pkg::REG_CELL_WIDTH) ? 32'(cw_q) : 32'(ch_q);
		cw_e     = (cw_q == '0) ? 12'd1 : cw_q;
		ch_e     = (ch_q == '0) ? 12'd1 : ch_q;
		cfg.cw   = cw_e;
		cfg.ch   = ch_e;
		cfg.cmin = (cw_e < ch_e) ? cw_e : ch_e;
	end

	ofg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.hold     (init_busy),
		.push     (push),
		.push_item(push_item),
		.full     (full)
	);

	ofg_queue #(
		.DEPTH(ofg_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (push_item),
		.full     (full),
		.pop      (pop),
		.dout     (head),
		.not_empty(not_empty)
	);

	ofg_back #(
		.GRID_SIZE(GRID_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head_valid(not_empty),
		.head      (head),
		.pop       (pop),
		.init_busy (init_busy),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ----- rtl/ofg_chk.sv -----
//------------------------------------------------------------------------------
// ofg_chk
// Port-level checks for the flow-field grid, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module ofg_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [23:0] force_x,
	input logic [23:0] force_y,
	input logic        in_grid,
	input logic        pready
);

	a_off_grid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !in_grid |-> force_x == '0 && force_y == '0)
		else $error("result word off grid carries a nonzero force");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("front accepted a word while still classifying");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(force_x) && $stable(force_y)
			&& $stable(in_grid))
		else $error("stalled result word changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind obstacle_flow_field_grid_top ofg_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.force_x  (rsp.force_x),
	.force_y  (rsp.force_y),
	.in_grid  (rsp.in_grid),
	.pready   (pready)
);

`default_nettype wire
